/* sv/u2g_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2g_pkg
// Shared types and constants for the UTF-8 to glyph slot mapper.
// ----------------------------------------------------------------------------
package u2g_pkg;

    localparam int CP_W    = 21;  // code point width
    localparam int LEN_W   = 3;   // sequence length width
    localparam int REM_W   = 2;   // continuation bytes still expected
    localparam int RNG_W   = 2;   // range number width
    localparam int RIU_W   = 2;   // ranges_in_use register width
    localparam int BYTE_W  = 8;
    localparam int ASCII_W = 7;

    // Register map, word index taken from paddr[4:2]
    localparam int          AIDX_W            = 3;
    localparam logic [2:0]  REG_RANGES_IN_USE = 3'd0;
    localparam logic [2:0]  REG_RANGE0_FIRST  = 3'd1;
    localparam logic [2:0]  REG_RANGE0_COUNT  = 3'd2;
    localparam int          REG_RANGE_STRIDE  = 2;

    // Reset values of the register file
    localparam logic [RIU_W-1:0] RANGES_IN_USE_RST = 2'd1;
    localparam logic [CP_W-1:0]  RANGE0_FIRST_RST  = 21'd32;
    localparam logic [CP_W-1:0]  RANGE0_COUNT_RST  = 21'd95;

    // Lead and continuation byte classes
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [1:0] CONT_TAG   = 2'b10;

    localparam logic [CP_W-1:0] DASH_CP = 21'h00002D;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    // Request and response of the shared range compare unit
    typedef struct packed {
        logic [CP_W-1:0] probe;
        logic [CP_W-1:0] first;
        logic [CP_W-1:0] count;
    } cmp_req_t;

    typedef struct packed {
        logic            hit;
        logic [CP_W-1:0] offset;
    } cmp_rsp_t;

endpackage

/* sv/u2g_range_cmp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2g_range_cmp
// Shared range compare unit: tests first <= probe < first + count.
// ----------------------------------------------------------------------------
module u2g_range_cmp (
    input  wire  u2g_pkg::cmp_req_t req,
    output logic                    rsp_hit,
    output logic [u2g_pkg::CP_W-1:0] rsp_offset
);

    logic [u2g_pkg::CP_W:0] limit;

    // Range end needs one extra bit; first + count may pass 2^21
    assign limit      = {1'b0, req.first} + {1'b0, req.count};
    assign rsp_hit    = (req.probe >= req.first) && ({1'b0, req.probe} < limit);
    assign rsp_offset = req.probe - req.first;

endmodule
`default_nettype wire

/* sv/u2g_regs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// u2g_regs
// APB register file holding the range count and the code-point ranges.
// ----------------------------------------------------------------------------
module u2g_regs #(
    parameter int MAX_RANGES = 3
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [4:0]                        paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    output logic [u2g_pkg::RIU_W-1:0]         ranges_in_use,
    output logic [u2g_pkg::CP_W-1:0]          range_first [MAX_RANGES],
    output logic [u2g_pkg::CP_W-1:0]          range_span  [MAX_RANGES]
);

    logic [u2g_pkg::RIU_W-1:0] riu_reg;
    logic [u2g_pkg::CP_W-1:0]  first_reg [MAX_RANGES];
    logic [u2g_pkg::CP_W-1:0]  count_reg [MAX_RANGES];
    logic [u2g_pkg::AIDX_W-1:0] widx;
    logic                       wr_en;

    assign pready = 1'b1;
    assign widx   = paddr[4:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            riu_reg <= u2g_pkg::RANGES_IN_USE_RST;
            for (int i = 0; i < MAX_RANGES; i++) begin
                first_reg[i] <= (i == 0) ? u2g_pkg::RANGE0_FIRST_RST : '0;
                count_reg[i] <= (i == 0) ? u2g_pkg::RANGE0_COUNT_RST : '0;
            end
        end else if (wr_en) begin
            if (widx == u2g_pkg::REG_RANGES_IN_USE) begin
                riu_reg <= pwdata[u2g_pkg::RIU_W-1:0];
            end
            for (int i = 0; i < MAX_RANGES; i++) begin
                if (widx == u2g_pkg::REG_RANGE0_FIRST
                        + u2g_pkg::AIDX_W'(u2g_pkg::REG_RANGE_STRIDE * i)) begin
                    first_reg[i] <= pwdata[u2g_pkg::CP_W-1:0];
                end
                if (widx == u2g_pkg::REG_RANGE0_COUNT
                        + u2g_pkg::AIDX_W'(u2g_pkg::REG_RANGE_STRIDE * i)) begin
                    count_reg[i] <= pwdata[u2g_pkg::CP_W-1:0];
                end
            end
        end
    end

    // Read back; unmapped words read as zero
    always_comb begin
        prdata = '0;
        if (widx == u2g_pkg::REG_RANGES_IN_USE) begin
            prdata = {{(32 - u2g_pkg::RIU_W){1'b0}}, riu_reg};
        end
        for (int i = 0; i < MAX_RANGES; i++) begin
            if (widx == u2g_pkg::REG_RANGE0_FIRST
                    + u2g_pkg::AIDX_W'(u2g_pkg::REG_RANGE_STRIDE * i)) begin
                prdata = {{(32 - u2g_pkg::CP_W){1'b0}}, first_reg[i]};
            end
            if (widx == u2g_pkg::REG_RANGE0_COUNT
                    + u2g_pkg::AIDX_W'(u2g_pkg::REG_RANGE_STRIDE * i)) begin
                prdata = {{(32 - u2g_pkg::CP_W){1'b0}}, count_reg[i]};
            end
        end
    end

    assign ranges_in_use = riu_reg;
    assign range_first   = first_reg;
    assign range_span    = count_reg;

endmodule
`default_nettype wire

/* sv/utf8_to_glyph_slot_mapper_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_glyph_slot_mapper_top
// Decodes a UTF-8 byte stream into code points and maps each code point to a
// glyph range number and slot offset through a sequenced range search.
// ----------------------------------------------------------------------------
// Sequence: a byte that yields no result is taken while idle and leaves the
//   sequencer idle. A byte that yields a result is accepted, then searched
//   over L ranges (L = min(ranges_in_use, MAX_RANGES)), with a dash pass after
//   a miss, and loaded into the output register once m_tready frees it.
// Throughput: one compare per cycle through the shared range compare unit; a
//   byte that yields two results (bad continuation) runs the search twice.
// s_tready is high only while the sequencer idles.
// Reset: synchronous, active low; control registers take their reset values and the
//   decoder drops any pending sequence. No clearing pass.
// ----------------------------------------------------------------------------
module utf8_to_glyph_slot_mapper_top #(
    parameter int MAX_RANGES = 3
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Input byte stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] text_byte
    // Result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // [20:0] code_point, [23:21] seq_length,
                                   // [25:24] range_number, [46:26] slot_offset
    output logic [2:0]  m_tuser,   // [0] malformed, [1] fallback_used,
                                   // [2] glyph_missing
    // Configuration
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CP_W  = u2g_pkg::CP_W;
    localparam int LEN_W = u2g_pkg::LEN_W;
    localparam int REM_W = u2g_pkg::REM_W;
    localparam int RNG_W = u2g_pkg::RNG_W;
    localparam int AW    = u2g_pkg::ASCII_W;
    // Search counter must reach the range count itself; index needs less
    localparam int CNT_W = $clog2(MAX_RANGES + 1);
    localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [u2g_pkg::RIU_W-1:0] ranges_in_use;
    logic [CP_W-1:0]           range_first [MAX_RANGES];
    logic [CP_W-1:0]           range_span  [MAX_RANGES];

    u2g_regs #(
        .MAX_RANGES (MAX_RANGES)
    ) u_regs (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .ranges_in_use (ranges_in_use),
        .range_first   (range_first),
        .range_span    (range_span)
    );

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    u2g_pkg::state_t state_reg, state_next;

    // Decoder state: partial code point, bytes still expected, total length
    logic [CP_W-1:0]  partial_reg, partial_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] seqlen_reg, seqlen_next;

    // Second result held back while the first one is searched
    logic             pend_valid_reg, pend_valid_next;
    logic [AW-1:0]    pend_cp_reg, pend_cp_next;
    logic             pend_bad_reg, pend_bad_next;

    // Search sequencer
    logic [CP_W-1:0]  cur_cp_reg, cur_cp_next;
    logic [LEN_W-1:0] cur_len_reg, cur_len_next;
    logic             cur_bad_reg, cur_bad_next;
    logic             fb_reg, fb_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             miss_reg, miss_next;
    logic [RNG_W-1:0] num_reg, num_next;
    logic [CP_W-1:0]  off_reg, off_next;

    // Output register
    logic             m_tvalid_reg, m_tvalid_next;
    logic [CP_W-1:0]  out_cp_reg, out_cp_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic             out_bad_reg, out_bad_next;
    logic             out_fb_reg, out_fb_next;
    logic             out_miss_reg, out_miss_next;
    logic [RNG_W-1:0] out_num_reg, out_num_next;
    logic [CP_W-1:0]  out_off_reg, out_off_next;

    // ------------------------------------------------------------------
    // Byte decoder
    // ------------------------------------------------------------------
    logic             s_accept;
    logic             b_cont;
    logic [CP_W-1:0]  cont_part;
    logic [REM_W-1:0] rem_dec;

    logic             lead_emit;
    logic [AW-1:0]    lead_cp;
    logic             lead_bad;
    logic [CP_W-1:0]  lead_part;
    logic [REM_W-1:0] lead_rem;
    logic [LEN_W-1:0] lead_len;

    logic             dec_emit;
    logic [CP_W-1:0]  dec_cp;
    logic [LEN_W-1:0] dec_len;
    logic             dec_bad;
    logic             dec_pend;
    logic [CP_W-1:0]  dec_part;
    logic [REM_W-1:0] dec_rem;
    logic [LEN_W-1:0] dec_seqlen;

    assign s_tready  = (state_reg == u2g_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign b_cont    = (s_tdata[7:6] == u2g_pkg::CONT_TAG);
    assign cont_part = {partial_reg[CP_W-7:0], s_tdata[5:0]};
    assign rem_dec   = rem_reg - REM_W'(1);

    // Classify a byte seen as a lead: ASCII, 2/3/4-byte lead, zero or stray
    always_comb begin
        lead_emit = 1'b0;
        lead_cp   = '0;
        lead_bad  = 1'b0;
        lead_part = '0;
        lead_rem  = '0;
        lead_len  = '0;
        priority if (s_tdata == '0) begin
            // End of text: nothing to report
        end else if (!s_tdata[7]) begin
            lead_emit = 1'b1;
            lead_cp   = s_tdata[AW-1:0];
        end else if ((s_tdata & u2g_pkg::LEAD2_MASK) == u2g_pkg::LEAD2_TAG) begin
            lead_part = CP_W'(s_tdata[4:0]);
            lead_rem  = REM_W'(1);
            lead_len  = LEN_W'(2);
        end else if ((s_tdata & u2g_pkg::LEAD3_MASK) == u2g_pkg::LEAD3_TAG) begin
            lead_part = CP_W'(s_tdata[3:0]);
            lead_rem  = REM_W'(2);
            lead_len  = LEN_W'(3);
        end else if ((s_tdata & u2g_pkg::LEAD4_MASK) == u2g_pkg::LEAD4_TAG) begin
            lead_part = CP_W'(s_tdata[2:0]);
            lead_rem  = REM_W'(3);
            lead_len  = LEN_W'(4);
        end else begin
            // Stray continuation or invalid lead
            lead_emit = 1'b1;
            lead_bad  = 1'b1;
        end
    end

    // Merge pending-sequence handling with the lead classification
    always_comb begin
        dec_emit   = 1'b0;
        dec_cp     = '0;
        dec_len    = LEN_W'(1);
        dec_bad    = 1'b0;
        dec_pend   = 1'b0;
        dec_part   = lead_part;
        dec_rem    = lead_rem;
        dec_seqlen = lead_len;
        priority if (rem_reg != '0 && b_cont) begin
            // Continuation: append six bits; finish when the count runs out
            if (rem_dec == '0) begin
                dec_emit   = 1'b1;
                dec_cp     = cont_part;
                dec_len    = seqlen_reg;
                dec_part   = '0;
                dec_rem    = '0;
                dec_seqlen = '0;
            end else begin
                dec_part   = cont_part;
                dec_rem    = rem_dec;
                dec_seqlen = seqlen_reg;
            end
        end else if (rem_reg != '0) begin
            // Broken sequence: report it, then reprocess the byte as a lead
            dec_emit = 1'b1;
            dec_bad  = 1'b1;
            dec_pend = lead_emit;
        end else begin
            dec_emit = lead_emit;
            dec_cp   = CP_W'(lead_cp);
            dec_bad  = lead_bad;
        end
    end

    // ------------------------------------------------------------------
    // Shared range compare unit
    // ------------------------------------------------------------------
    u2g_pkg::cmp_req_t cmp_req;
    logic              cmp_hit;
    logic [CP_W-1:0]   cmp_off;
    logic [CNT_W-1:0]  lim;
    logic              at_end;
    logic              srch_done;
    logic              out_free;

    // Searched ranges: ranges_in_use clamped to what the block stores
    assign lim = (CNT_W'(ranges_in_use) > CNT_W'(MAX_RANGES) ||
                  {{(2 + CNT_W){1'b0}}, ranges_in_use} > (2 + CNT_W + 2)'(MAX_RANGES))
                 ? CNT_W'(MAX_RANGES) : CNT_W'(ranges_in_use);
    assign at_end = (idx_reg == lim);

    always_comb begin
        cmp_req.probe = fb_reg ? u2g_pkg::DASH_CP : cur_cp_reg;
        cmp_req.first = '0;
        cmp_req.count = '0;
        if (!at_end) begin
            cmp_req.first = range_first[idx_reg[IDX_W-1:0]];
            cmp_req.count = range_span[idx_reg[IDX_W-1:0]];
        end
    end

    u2g_range_cmp u_cmp (
        .req        (cmp_req),
        .rsp_hit    (cmp_hit),
        .rsp_offset (cmp_off)
    );

    assign srch_done = at_end ? fb_reg : cmp_hit;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            u2g_pkg::ST_IDLE: begin
                if (s_accept && dec_emit) begin
                    state_next = u2g_pkg::ST_SEARCH;
                end
            end
            u2g_pkg::ST_SEARCH: begin
                if (srch_done) begin
                    state_next = u2g_pkg::ST_EMIT;
                end
            end
            u2g_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = pend_valid_reg ? u2g_pkg::ST_SEARCH : u2g_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = u2g_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: datapath
    // ------------------------------------------------------------------
    always_comb begin
        partial_next    = partial_reg;
        rem_next        = rem_reg;
        seqlen_next     = seqlen_reg;
        pend_valid_next = pend_valid_reg;
        pend_cp_next    = pend_cp_reg;
        pend_bad_next   = pend_bad_reg;
        cur_cp_next     = cur_cp_reg;
        cur_len_next    = cur_len_reg;
        cur_bad_next    = cur_bad_reg;
        fb_next         = fb_reg;
        idx_next        = idx_reg;
        miss_next       = miss_reg;
        num_next        = num_reg;
        off_next        = off_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_cp_next     = out_cp_reg;
        out_len_next    = out_len_reg;
        out_bad_next    = out_bad_reg;
        out_fb_next     = out_fb_reg;
        out_miss_next   = out_miss_reg;
        out_num_next    = out_num_reg;
        out_off_next    = out_off_reg;

        unique case (state_reg)
            u2g_pkg::ST_IDLE: begin
                if (s_accept) begin
                    partial_next    = dec_part;
                    rem_next        = dec_rem;
                    seqlen_next     = dec_seqlen;
                    pend_valid_next = dec_pend;
                    pend_cp_next    = lead_cp;
                    pend_bad_next   = lead_bad;
                    cur_cp_next     = dec_cp;
                    cur_len_next    = dec_len;
                    cur_bad_next    = dec_bad;
                    fb_next         = 1'b0;
                    idx_next        = '0;
                end
            end
            u2g_pkg::ST_SEARCH: begin
                if (at_end) begin
                    // No range held the probe: retry with dash, else give up
                    if (fb_reg) begin
                        miss_next = 1'b1;
                        num_next  = '0;
                        off_next  = '0;
                    end else begin
                        fb_next  = 1'b1;
                        idx_next = '0;
                    end
                end else if (cmp_hit) begin
                    miss_next = 1'b0;
                    num_next  = RNG_W'(idx_reg);
                    off_next  = cmp_off;
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            u2g_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    out_cp_next   = cur_cp_reg;
                    out_len_next  = cur_len_reg;
                    out_bad_next  = cur_bad_reg;
                    out_fb_next   = fb_reg;
                    out_miss_next = miss_reg;
                    out_num_next  = num_reg;
                    out_off_next  = off_reg;
                    if (pend_valid_reg) begin
                        // Advance to the byte reprocessed as a lead
                        pend_valid_next = 1'b0;
                        cur_cp_next     = CP_W'(pend_cp_reg);
                        cur_len_next    = LEN_W'(1);
                        cur_bad_next    = pend_bad_reg;
                        fb_next         = 1'b0;
                        idx_next        = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= u2g_pkg::ST_IDLE;
            partial_reg    <= '0;
            rem_reg        <= '0;
            seqlen_reg     <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            partial_reg    <= partial_next;
            rem_reg        <= rem_next;
            seqlen_reg     <= seqlen_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_cp_reg  <= pend_cp_next;
        pend_bad_reg <= pend_bad_next;
        cur_cp_reg   <= cur_cp_next;
        cur_len_reg  <= cur_len_next;
        cur_bad_reg  <= cur_bad_next;
        fb_reg       <= fb_next;
        idx_reg      <= idx_next;
        miss_reg     <= miss_next;
        num_reg      <= num_next;
        off_reg      <= off_next;
        out_cp_reg   <= out_cp_next;
        out_len_reg  <= out_len_next;
        out_bad_reg  <= out_bad_next;
        out_fb_reg   <= out_fb_next;
        out_miss_reg <= out_miss_next;
        out_num_reg  <= out_num_next;
        out_off_reg  <= out_off_next;
    end

    // ------------------------------------------------------------------
    // Output packing
    // ------------------------------------------------------------------
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_off_reg, out_num_reg, out_len_reg, out_cp_reg};
    assign m_tuser  = {out_miss_reg, out_fb_reg, out_bad_reg};

`ifndef ASSERT_OFF
    // A missing glyph only follows a failed dash lookup and reports slot zero
    a_miss_after_fb: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tuser[1] && m_tdata[46:24] == '0)
        else $error("glyph_missing without fallback or with nonzero slot");

    // Malformed results carry code point zero and length one
    a_bad_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[20:0] == '0 && m_tdata[23:21] == LEN_W'(1))
        else $error("malformed result with nonzero code point or length");

    // A held-back second result never survives a return to idle
    a_pend_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> state_reg != u2g_pkg::ST_IDLE)
        else $error("pending result left behind in idle");

    // While a sequence is open its length exceeds the bytes still expected
    a_seq_len: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_reg != '0 |-> seqlen_reg > LEN_W'(rem_reg))
        else $error("sequence length inconsistent with remaining bytes");

    // The search counter never runs past the searched ranges
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == u2g_pkg::ST_SEARCH |-> idx_reg <= lim)
        else $error("range search index out of bounds");
`endif

endmodule
`default_nettype wire
